[hdl/pwf_pkg.sv]
// pwf_pkg: shared constants, codes and types of the pooled work fifo
// used by pwf_cell and pooled_work_fifo; no dependencies
package pwf_pkg;

    // default sizes handed to the top level
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int ARG_BITS_DEF    = 16;

    // fixed field widths of the request and result channels
    localparam int OP_W      = 2;
    localparam int WORKER_W  = 8;
    localparam int COMMAND_W = 8;
    localparam int IN_ARG_W  = 16;
    localparam int STATUS_W  = 3;
    localparam int REMOVED_W = 4;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // operation codes
    localparam logic [OP_W-1:0] OP_SCHEDULE   = 2'd0;
    localparam logic [OP_W-1:0] OP_DESCHEDULE = 2'd1;
    localparam logic [OP_W-1:0] OP_POP        = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOMEM    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

[hdl/pwf_cell.sv]
// pwf_cell: one queue position holding worker, command and argument
// depends on pwf_pkg for field widths and the cell control struct
module pwf_cell #(
    parameter int ARG_BITS = pwf_pkg::ARG_BITS_DEF
) (
    input  logic                           aclk,
    input  pwf_pkg::cell_ctrl_t            ctrl,
    input  logic [pwf_pkg::WORKER_W-1:0]   nb_worker,
    input  logic [pwf_pkg::COMMAND_W-1:0]  nb_command,
    input  logic [ARG_BITS-1:0]            nb_argument,
    input  logic [pwf_pkg::WORKER_W-1:0]   wr_worker,
    input  logic [pwf_pkg::COMMAND_W-1:0]  wr_command,
    input  logic [ARG_BITS-1:0]            wr_argument,
    output logic [pwf_pkg::WORKER_W-1:0]   worker,
    output logic [pwf_pkg::COMMAND_W-1:0]  command,
    output logic [ARG_BITS-1:0]            argument
);

    logic [pwf_pkg::WORKER_W-1:0]  worker_reg, worker_next;
    logic [pwf_pkg::COMMAND_W-1:0] command_reg, command_next;
    logic [ARG_BITS-1:0]           argument_reg, argument_next;

    // load wins over the shift from the neighbor toward the head
    always_comb begin
        worker_next   = worker_reg;
        command_next  = command_reg;
        argument_next = argument_reg;
        if (ctrl.load) begin
            worker_next   = wr_worker;
            command_next  = wr_command;
            argument_next = wr_argument;
        end else if (ctrl.shift) begin
            worker_next   = nb_worker;
            command_next  = nb_command;
            argument_next = nb_argument;
        end
    end

    // payload only, no reset
    always_ff @(posedge aclk) begin
        worker_reg   <= worker_next;
        command_reg  <= command_next;
        argument_reg <= argument_next;
    end

    assign worker   = worker_reg;
    assign command  = command_reg;
    assign argument = argument_reg;

endmodule

[hdl/pooled_work_fifo.sv]
// pooled_work_fifo: top level, request sequencer and the row of queue cells
// depends on pwf_pkg and pwf_cell
//
// usage:
//   requests enter on the s_ channel; s_tuser carries the operation
//   (schedule, deschedule, pop) and s_tdata the worker, command and argument.
//   every request yields exactly one result on the m_ channel; m_tuser holds
//   the status and m_tdata the popped entry, the removed count and the
//   empty flag.
//   the queue is a row of cells, cell 0 the head; entries move one cell
//   toward the head on every pop and on every deschedule step.
// sequence:
//   schedule, pop and rejected requests: the request is captured, then
//   executed in the exec state, which loads its result into the output register.
//   deschedule walks the queue one entry per cycle through the head cell,
//   re-appending kept entries at the tail, and the walk does not stall;
//   its result is then loaded into the output register in the done state.
//   one request is in work at a time; s_tready is high whenever the
//   sequencer is idle, even while a result waits in the output register.
// reset and stall:
//   aresetn low empties the queue and drops any pending result.
//   while m_tready is low a finished result holds in the output register
//   and the next request waits at the point of producing its own result.
module pooled_work_fifo #(
    parameter int QUEUE_DEPTH = pwf_pkg::QUEUE_DEPTH_DEF,
    parameter int ARG_BITS    = pwf_pkg::ARG_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: worker_id[7:0], command[15:8], argument[31:16]
    input  logic [pwf_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: op[1:0]
    input  logic [pwf_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: popped_worker[7:0], popped_command[15:8],
    // popped_argument[31:16], removed_count[35:32], now_empty[36], zero[39:37]
    output logic [pwf_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: status[2:0]
    output logic [pwf_pkg::STATUS_W-1:0]   m_tuser
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int WW = pwf_pkg::WORKER_W;
    localparam int CMW = pwf_pkg::COMMAND_W;
    localparam int IAW = pwf_pkg::IN_ARG_W;
    localparam int RW = pwf_pkg::REMOVED_W;
    localparam int SW = pwf_pkg::STATUS_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] wleft_reg, wleft_next;
    logic [CW-1:0] rem_reg, rem_next;

    // captured request
    logic [pwf_pkg::OP_W-1:0] req_op_reg;
    logic [WW-1:0]            req_worker_reg;
    logic [CMW-1:0]           req_command_reg;
    logic [ARG_BITS-1:0]      req_argument_reg;

    // output register
    logic                out_valid_reg;
    logic [SW-1:0]       out_status_reg;
    logic [WW-1:0]       out_worker_reg;
    logic [CMW-1:0]      out_command_reg;
    logic [IAW-1:0]      out_argument_reg;
    logic [RW-1:0]       out_removed_reg;
    logic                out_empty_reg;

    // cell row
    logic [WW-1:0]       cell_worker   [QUEUE_DEPTH];
    logic [CMW-1:0]      cell_command  [QUEUE_DEPTH];
    logic [ARG_BITS-1:0] cell_argument [QUEUE_DEPTH];

    logic                shift_all;
    logic                load_en;
    logic                wr_from_head;
    logic [CW-1:0]       wr_pos;
    logic [WW-1:0]       wr_worker;
    logic [CMW-1:0]      wr_command;
    logic [ARG_BITS-1:0] wr_argument;

    logic          out_free;
    logic          out_load;
    logic          head_match;
    logic [SW-1:0] res_status;
    logic          res_pop;
    logic          res_removed_en;
    logic [RW-1:0] rem_sat;
    logic [CW+RW-1:0]        rem_wide;
    logic [ARG_BITS+IAW-1:0] in_arg_wide;
    logic [ARG_BITS+IAW-1:0] head_arg_wide;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign head_match = (cell_worker[0] == req_worker_reg)
                     && (cell_command[0] == req_command_reg);

    // argument width adaption on the way in and out
    assign in_arg_wide   = {{ARG_BITS{1'b0}}, s_tdata[WW+CMW +: IAW]};
    assign head_arg_wide = {{IAW{1'b0}}, cell_argument[0]};

    // removed count saturates at the field maximum
    assign rem_wide = {{RW{1'b0}}, rem_reg};
    assign rem_sat  = (rem_wide > (CW+RW)'({RW{1'b1}})) ? {RW{1'b1}} : rem_wide[RW-1:0];

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wleft_next     = wleft_reg;
        rem_next       = rem_reg;
        shift_all      = 1'b0;
        load_en        = 1'b0;
        wr_from_head   = 1'b0;
        wr_pos         = cnt_reg;
        out_load       = 1'b0;
        res_status     = pwf_pkg::ST_INVALID;
        res_pop        = 1'b0;
        res_removed_en = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (req_op_reg)
                    pwf_pkg::OP_SCHEDULE: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (req_worker_reg == '0) begin
                                res_status = pwf_pkg::ST_INVALID;
                            end else if (cnt_reg == CW'(QUEUE_DEPTH)) begin
                                res_status = pwf_pkg::ST_NOMEM;
                            end else begin
                                res_status = pwf_pkg::ST_OK;
                                load_en    = 1'b1;
                                cnt_next   = cnt_reg + CW'(1);
                            end
                        end
                    end
                    pwf_pkg::OP_DESCHEDULE: begin
                        if (req_worker_reg == '0) begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                res_status = pwf_pkg::ST_INVALID;
                                state_next = S_IDLE;
                            end
                        end else if (cnt_reg == '0) begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                res_status = pwf_pkg::ST_NOTFOUND;
                                state_next = S_IDLE;
                            end
                        end else begin
                            wleft_next = cnt_reg;
                            rem_next   = '0;
                            state_next = S_WALK;
                        end
                    end
                    pwf_pkg::OP_POP: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (cnt_reg == '0) begin
                                res_status = pwf_pkg::ST_EMPTY;
                            end else begin
                                res_status = pwf_pkg::ST_OK;
                                res_pop    = 1'b1;
                                shift_all  = 1'b1;
                                cnt_next   = cnt_reg - CW'(1);
                            end
                        end
                    end
                    default: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            res_status = pwf_pkg::ST_INVALID;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_WALK: begin
                // head leaves; kept entries go back in at the tail
                shift_all  = 1'b1;
                wleft_next = wleft_reg - CW'(1);
                if (head_match) begin
                    cnt_next = cnt_reg - CW'(1);
                    rem_next = rem_reg + CW'(1);
                end else begin
                    load_en      = 1'b1;
                    wr_from_head = 1'b1;
                    wr_pos       = cnt_reg - CW'(1);
                end
                if (wleft_reg == CW'(1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    res_status     = pwf_pkg::ST_NOTFOUND;
                    res_removed_en = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            wleft_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wleft_reg <= wleft_next;
            rem_reg   <= rem_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_op_reg       <= s_tuser;
            req_worker_reg   <= s_tdata[0 +: WW];
            req_command_reg  <= s_tdata[WW +: CMW];
            req_argument_reg <= in_arg_wide[ARG_BITS-1:0];
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg   <= res_status;
            out_worker_reg   <= res_pop ? cell_worker[0] : '0;
            out_command_reg  <= res_pop ? cell_command[0] : '0;
            out_argument_reg <= res_pop ? head_arg_wide[IAW-1:0] : '0;
            out_removed_reg  <= res_removed_en ? rem_sat : '0;
            out_empty_reg    <= (cnt_next == '0);
        end
    end

    // write data for the cell row
    assign wr_worker   = wr_from_head ? cell_worker[0] : req_worker_reg;
    assign wr_command  = wr_from_head ? cell_command[0] : req_command_reg;
    assign wr_argument = wr_from_head ? cell_argument[0] : req_argument_reg;

    // row of cells, each fed by its neighbor toward the tail
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        pwf_pkg::cell_ctrl_t ctrl;
        logic [WW-1:0]       nb_worker;
        logic [CMW-1:0]      nb_command;
        logic [ARG_BITS-1:0] nb_argument;

        assign ctrl.shift = shift_all;
        assign ctrl.load  = load_en && (wr_pos == CW'(i));

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign nb_worker   = cell_worker[i];
            assign nb_command  = cell_command[i];
            assign nb_argument = cell_argument[i];
        end else begin : g_mid
            assign nb_worker   = cell_worker[i+1];
            assign nb_command  = cell_command[i+1];
            assign nb_argument = cell_argument[i+1];
        end

        pwf_cell #(
            .ARG_BITS(ARG_BITS)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .nb_worker  (nb_worker),
            .nb_command (nb_command),
            .nb_argument(nb_argument),
            .wr_worker  (wr_worker),
            .wr_command (wr_command),
            .wr_argument(wr_argument),
            .worker     (cell_worker[i]),
            .command    (cell_command[i]),
            .argument   (cell_argument[i])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_empty_reg, out_removed_reg, out_argument_reg,
                       out_command_reg, out_worker_reg};

endmodule

[bench/tb_pooled_work_fifo.sv]
// tb_pooled_work_fifo: self-checking bench for the pooled work fifo
// directed and random requests with a queue-based predictor; needs pwf_pkg and the rtl
`timescale 1ns / 100ps

module tb_pooled_work_fifo;

    // op code that the block does not decode
    localparam logic [pwf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int POOL_SLOTS  = pwf_pkg::QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_REQUESTS = 2000;

    typedef struct {
        logic [pwf_pkg::WORKER_W-1:0]  worker;
        logic [pwf_pkg::COMMAND_W-1:0] command;
        logic [pwf_pkg::IN_ARG_W-1:0]  argument;
    } work_entry_t;

    typedef struct {
        logic [pwf_pkg::STATUS_W-1:0]  status;
        logic [pwf_pkg::WORKER_W-1:0]  worker;
        logic [pwf_pkg::COMMAND_W-1:0] command;
        logic [pwf_pkg::IN_ARG_W-1:0]  argument;
        logic [pwf_pkg::REMOVED_W-1:0] removed;
        logic                          empty;
    } work_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [pwf_pkg::S_TDATA_W-1:0] s_tdata;
    logic [pwf_pkg::OP_W-1:0]      s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [pwf_pkg::M_TDATA_W-1:0] m_tdata;
    logic [pwf_pkg::STATUS_W-1:0]  m_tuser;

    work_entry_t  queued_work[$];
    work_result_t pending_results[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           gaps_on = 1'b1;
    bit           sink_steady = 1'b0;

    pooled_work_fifo dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= sink_steady ? 1'b1 : ($urandom_range(99) >= 11);
    end

    // predictor: apply one request to the queue copy, return the result
    function automatic work_result_t apply_request(logic [pwf_pkg::OP_W-1:0] op,
            logic [pwf_pkg::WORKER_W-1:0] worker, logic [pwf_pkg::COMMAND_W-1:0] command,
            logic [pwf_pkg::IN_ARG_W-1:0] argument);
        work_result_t res;
        work_entry_t  entry;
        work_entry_t  survivors[$];
        int           hits;
        res = '{status: pwf_pkg::ST_INVALID, worker: '0, command: '0, argument: '0,
                removed: '0, empty: 1'b0};
        hits = 0;
        case (op)
            pwf_pkg::OP_SCHEDULE: begin
                if (worker == 0) begin
                    res.status = pwf_pkg::ST_INVALID;
                end else if (queued_work.size() >= POOL_SLOTS) begin
                    res.status = pwf_pkg::ST_NOMEM;
                end else begin
                    entry = '{worker: worker, command: command, argument: argument};
                    queued_work.push_back(entry);
                    res.status = pwf_pkg::ST_OK;
                end
            end
            pwf_pkg::OP_DESCHEDULE: begin
                if (worker == 0) begin
                    res.status = pwf_pkg::ST_INVALID;
                end else begin
                    foreach (queued_work[i]) begin
                        if (queued_work[i].worker == worker &&
                            queued_work[i].command == command)
                            hits++;
                        else
                            survivors.push_back(queued_work[i]);
                    end
                    queued_work = survivors;
                    // status reads not found even when entries went away
                    res.status = pwf_pkg::ST_NOTFOUND;
                    res.removed = (hits > 15) ? 4'd15 : hits[pwf_pkg::REMOVED_W-1:0];
                end
            end
            pwf_pkg::OP_POP: begin
                if (queued_work.size() == 0) begin
                    res.status = pwf_pkg::ST_EMPTY;
                end else begin
                    entry = queued_work.pop_front();
                    res.status = pwf_pkg::ST_OK;
                    res.worker = entry.worker;
                    res.command = entry.command;
                    res.argument = entry.argument;
                end
            end
            default: res.status = pwf_pkg::ST_INVALID;
        endcase
        res.empty = (queued_work.size() == 0);
        return res;
    endfunction

    // result checker
    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        work_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0h data %0h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", want.status, m_tuser);
                compare_field("popped_worker", want.worker, m_tdata[7:0]);
                compare_field("popped_command", want.command, m_tdata[15:8]);
                compare_field("popped_argument", want.argument, m_tdata[31:16]);
                compare_field("removed_count", want.removed, m_tdata[35:32]);
                compare_field("now_empty", want.empty, m_tdata[36]);
                compare_field("pad bits", 0, m_tdata[39:37]);
            end
        end
    end

    // send one request; entered and left at a falling edge
    task automatic send_request(logic [pwf_pkg::OP_W-1:0] op,
            logic [pwf_pkg::WORKER_W-1:0] worker,
            logic [pwf_pkg::COMMAND_W-1:0] command,
            logic [pwf_pkg::IN_ARG_W-1:0] argument);
        while (gaps_on && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {argument, command, worker};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(apply_request(op, worker, command, argument));
        @(negedge aclk);
    endtask

    // hold off the sender until every result is back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic test_empty_queue();
        send_request(pwf_pkg::OP_POP, 8'd0, 8'd0, 16'd0);
        send_request(pwf_pkg::OP_DESCHEDULE, 8'd5, 8'd5, 16'd0);
        send_request(OP_UNUSED, 8'd0, 8'd0, 16'd0);
        send_request(pwf_pkg::OP_SCHEDULE, 8'd0, 8'hFF, 16'hFFFF);
    endtask

    task automatic test_fill_to_capacity();
        send_request(pwf_pkg::OP_SCHEDULE, 8'hFF, 8'hFF, 16'hFFFF);
        send_request(pwf_pkg::OP_SCHEDULE, 8'd1, 8'd0, 16'd0);
        send_request(pwf_pkg::OP_SCHEDULE, 8'd3, 8'd9, 16'h1234);
        send_request(pwf_pkg::OP_SCHEDULE, 8'd2, 8'd7, 16'hA5A5);
        send_request(pwf_pkg::OP_SCHEDULE, 8'd3, 8'd9, 16'h5A5A);
        send_request(pwf_pkg::OP_SCHEDULE, 8'd3, 8'd8, 16'h0F0F);
        send_request(pwf_pkg::OP_SCHEDULE, 8'd3, 8'd9, 16'hF0F0);
        send_request(pwf_pkg::OP_SCHEDULE, 8'h80, 8'h80, 16'h8000);
        // pool full
        send_request(pwf_pkg::OP_SCHEDULE, 8'd4, 8'd4, 16'h4444);
    endtask

    task automatic test_deschedule_matches();
        send_request(pwf_pkg::OP_DESCHEDULE, 8'd0, 8'd9, 16'd0);
        send_request(pwf_pkg::OP_DESCHEDULE, 8'd3, 8'd9, 16'd0);
        send_request(pwf_pkg::OP_DESCHEDULE, 8'd3, 8'd7, 16'd0);
        send_request(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
    endtask

    task automatic test_drain_by_pop();
        repeat (6)
            send_request(pwf_pkg::OP_POP, 8'd0, 8'd0, 16'd0);
    endtask

    // mostly small worker and command sets so deschedules hit, with fill and drain phases
    task automatic test_random_traffic();
        logic [pwf_pkg::OP_W-1:0]      op;
        logic [pwf_pkg::WORKER_W-1:0]  worker;
        logic [pwf_pkg::COMMAND_W-1:0] command;
        logic [pwf_pkg::IN_ARG_W-1:0]  argument;
        int                            roll;
        int                            pick;
        bit                            filling;
        filling = 1'b1;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 60 == 0)
                filling = !filling;
            if (n % 250 == 249)
                wait_results_drained();
            gaps_on = !(n >= 600 && n < 1000);
            sink_steady = (n >= 600 && n < 1000);
            worker  = ($urandom_range(99) < 75) ? pwf_pkg::WORKER_W'($urandom_range(1, 3))
                                                : pwf_pkg::WORKER_W'($urandom_range(0, 255));
            command = ($urandom_range(99) < 75) ? pwf_pkg::COMMAND_W'($urandom_range(0, 3))
                                                : pwf_pkg::COMMAND_W'($urandom_range(0, 255));
            argument = pwf_pkg::IN_ARG_W'($urandom_range(0, 65535));
            roll = $urandom_range(99);
            if (roll < 2)
                op = OP_UNUSED;
            else if (roll < (filling ? 62 : 30))
                op = pwf_pkg::OP_SCHEDULE;
            else if (roll < (filling ? 80 : 55))
                op = pwf_pkg::OP_DESCHEDULE;
            else
                op = pwf_pkg::OP_POP;
            // aim most deschedules at an entry really in the queue
            if (op == pwf_pkg::OP_DESCHEDULE && queued_work.size() != 0
                    && $urandom_range(99) < 70) begin
                pick = $urandom_range(queued_work.size() - 1);
                worker = queued_work[pick].worker;
                command = queued_work[pick].command;
            end
            send_request(op, worker, command, argument);
        end
        gaps_on = 1'b1;
        sink_steady = 1'b0;
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_queue();
        test_fill_to_capacity();
        test_deschedule_matches();
        test_drain_by_pop();
        test_random_traffic();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
